// ===== rtl/cwad_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and digit helpers for the clock/display unit.
// No dependencies; imported by every module of the unit.
package cwad_pkg;

    localparam int TICK_W  = 7;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int LIGHT_W = 8;
    localparam int TEMP_W  = 12;
    localparam int MAG_W   = 11;
    localparam int PHASE_W = 8;
    localparam int SEG_W   = 8;

    localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;

    localparam logic [PHASE_W-1:0] TIME_PHASE_RESET = 8'd6;
    localparam logic [PHASE_W-1:0] TEMP_PHASE_RESET = 8'd2;

    // item kinds carried on the input tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // register indexes (word address bit 2)
    localparam logic REG_TIME_PHASE = 1'b0;
    localparam logic REG_TEMP_PHASE = 1'b1;

    localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    typedef struct packed {
        logic                 cmd;
        logic [HOUR_W-1:0]    set_hour;
        logic [MIN_W-1:0]     set_minute;
        logic [SEC_W-1:0]     set_second;
        logic [LIGHT_W-1:0]   light_sample;
        logic signed [TEMP_W-1:0] temp_tenths;
    } cwad_item_t;

    // state after one item, handed from the counters to the formatter
    typedef struct packed {
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic               showing_time;
        logic               report;
        logic [LIGHT_W-1:0] light;
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
    } cwad_snap_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } cwad_digits_t;

    // a..g in bits 0..6; anything above nine is blank
    function automatic logic [SEG_W-1:0] seg_of(input logic [4:0] d);
        logic [SEG_W-1:0] s;
        begin
            case (d)
                5'd0:    s = 8'h3F;
                5'd1:    s = 8'h06;
                5'd2:    s = 8'h5B;
                5'd3:    s = 8'h4F;
                5'd4:    s = 8'h66;
                5'd5:    s = 8'h6D;
                5'd6:    s = 8'h7D;
                5'd7:    s = 8'h07;
                5'd8:    s = 8'h7F;
                5'd9:    s = 8'h6F;
                default: s = SEG_BLANK;
            endcase
            return s;
        end
    endfunction

    // tens and units of a value below 128 (tens may exceed nine)
    function automatic cwad_digits_t split_tens(input logic [6:0] v);
        cwad_digits_t r;
        logic [6:0]   t10;
        begin
            if (v >= 7'd120)      r.tens = 4'd12;
            else if (v >= 7'd110) r.tens = 4'd11;
            else if (v >= 7'd100) r.tens = 4'd10;
            else if (v >= 7'd90)  r.tens = 4'd9;
            else if (v >= 7'd80)  r.tens = 4'd8;
            else if (v >= 7'd70)  r.tens = 4'd7;
            else if (v >= 7'd60)  r.tens = 4'd6;
            else if (v >= 7'd50)  r.tens = 4'd5;
            else if (v >= 7'd40)  r.tens = 4'd4;
            else if (v >= 7'd30)  r.tens = 4'd3;
            else if (v >= 7'd20)  r.tens = 4'd2;
            else if (v >= 7'd10)  r.tens = 4'd1;
            else                  r.tens = 4'd0;
            t10     = {r.tens, 3'b000} + {2'b00, r.tens, 1'b0};
            r.units = 4'(v - t10);
            return r;
        end
    endfunction

    // hundreds of an 11-bit magnitude: reciprocal 1311 / 2^17 is exact below 2048
    function automatic logic [4:0] hundreds_of(input logic [MAG_W-1:0] m);
        logic [21:0] prod;
        begin
            prod = 22'(m) * 22'd1311;
            return prod[21:17];
        end
    endfunction

endpackage

// ===== rtl/clock_with_alternating_display_unit.sv =====
`timescale 1ns / 1ps
// Digital clock with alternating time / temperature display, top level.
// Depends on cwad_pkg, cwad_core and cwad_fmt.
//
// Usage:
//   Input stream (s_*): one item per 10 ms tick (tuser = 0) or a set-time
//   event (tuser = 1). Every item gives exactly one result item on m_*.
//   Result: time after the item, display mode, four digit segment patterns
//   and, on a minute rollover, a report of the latched brightness and
//   temperature.
//   Path: an accepted item passes the counter stage, then the segment-encoding
//   result register, which drives m_tvalid.
//   Throughput: one item per cycle unless stalled; the two stages each pass on
//   while the next one is free, so a new item is taken while a result waits.
//   Stall: when m_tready is low the result register holds, the counter stage
//   fills behind it and s_tready drops only once both are occupied.
//   Reset: clock 00:00:00, prescaler and phase at zero, display on time,
//   latched samples zero, phase registers 6 and 2 seconds.
//   Configuration (APB, byte address 0 = time phase, 4 = temperature phase)
//   is the user's to write only while no item is in flight; not enforced here.
module clock_with_alternating_display_unit
    import cwad_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 100
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // set_hour[4:0], set_minute[10:5], set_second[16:11], light_sample[24:17],
    // temp_tenths[36:25], zero fill [39:37]
    input  logic [39:0] s_tdata,
    // cmd
    input  logic        s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // hours[4:0], minutes[10:5], seconds[16:11], seg_first[24:17],
    // seg_second[32:25], seg_third[40:33], seg_fourth[48:41],
    // report_light[56:49], report_negative[57], report_magnitude[68:58],
    // zero fill [71:69]
    output logic [71:0] m_tdata,
    // showing_time[0], report_valid[1]
    output logic [1:0]  m_tuser
);

    logic [PHASE_W-1:0] time_phase_reg;
    logic [PHASE_W-1:0] temp_phase_reg;
    logic               cfg_write;

    cwad_item_t         item;
    cwad_snap_t         snap;
    logic               snap_valid;
    logic               snap_ready;

    // ---- configuration registers ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_phase_reg <= TIME_PHASE_RESET;
            temp_phase_reg <= TEMP_PHASE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TIME_PHASE: time_phase_reg <= pwdata[PHASE_W-1:0];
                REG_TEMP_PHASE: temp_phase_reg <= pwdata[PHASE_W-1:0];
                default:        time_phase_reg <= time_phase_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TIME_PHASE: prdata = {24'b0, time_phase_reg};
            REG_TEMP_PHASE: prdata = {24'b0, temp_phase_reg};
            default:        prdata = '0;
        endcase
    end

    // ---- unpack the input item ----
    assign item.cmd          = s_tuser;
    assign item.set_hour     = s_tdata[4:0];
    assign item.set_minute   = s_tdata[10:5];
    assign item.set_second   = s_tdata[16:11];
    assign item.light_sample = s_tdata[24:17];
    assign item.temp_tenths  = s_tdata[36:25];

    // counters, phase and latch; state after each item is the stage output
    cwad_core #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .item       (item),
        .time_phase (time_phase_reg),
        .temp_phase (temp_phase_reg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    // digit split, segment lookup and report gating into the result register
    cwad_fmt u_fmt (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_user   (m_tuser)
    );

endmodule

// ===== rtl/cwad_core.sv =====
`timescale 1ns / 1ps
// Time counters, display phase, latch; one item per cycle unless stalled.
// Depends on cwad_pkg.
module cwad_core
    import cwad_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cwad_item_t         item,
    input  logic [PHASE_W-1:0] time_phase,
    input  logic [PHASE_W-1:0] temp_phase,
    output logic               snap_valid,
    input  logic               snap_ready,
    output cwad_snap_t         snap
);

    localparam logic [TICK_W-1:0] TICK_WRAP = TICK_W'(TICKS_PER_SECOND);

    logic [TICK_W-1:0]  tick_reg,   tick_next;
    logic [SEC_W-1:0]   sec_reg,    sec_next;
    logic [MIN_W-1:0]   min_reg,    min_next;
    logic [HOUR_W-1:0]  hour_reg,   hour_next;
    logic               mode_reg,   mode_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [MAG_W-1:0]   mag_reg,    mag_next;
    logic               neg_reg,    neg_next;
    logic [LIGHT_W-1:0] light_reg,  light_next;
    logic               report_reg, report_next;
    logic               valid_reg,  valid_next;

    logic               accept;
    logic [TICK_W-1:0]  tick_inc;
    logic [PHASE_W-1:0] phase_inc;
    logic [TEMP_W-1:0]  neg_raw;
    logic [MAG_W-1:0]   sample_mag;

    assign in_ready = !valid_reg || snap_ready;
    assign accept   = in_valid && in_ready;

    assign tick_inc  = tick_reg + 1'b1;
    assign phase_inc = phase_reg + 1'b1;

    // magnitude of the sample; the most negative code saturates
    assign neg_raw = ~item.temp_tenths + 1'b1;
    always_comb
    begin
        if (!item.temp_tenths[TEMP_W-1])
            sample_mag = item.temp_tenths[MAG_W-1:0];
        else if (neg_raw[TEMP_W-1])
            sample_mag = {MAG_W{1'b1}};
        else
            sample_mag = neg_raw[MAG_W-1:0];
    end

    always_comb
    begin
        tick_next   = tick_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        mode_next   = mode_reg;
        phase_next  = phase_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        light_next  = light_reg;
        report_next = report_reg;
        valid_next  = valid_reg;

        if (accept)
        begin
            valid_next  = 1'b1;
            report_next = 1'b0;
            if (item.cmd == CMD_SET)
            begin
                hour_next = item.set_hour;
                min_next  = item.set_minute;
                sec_next  = item.set_second;
            end
            else
            begin
                tick_next = tick_inc;
                if (tick_inc >= TICK_WRAP)
                begin
                    tick_next  = '0;
                    phase_next = phase_inc;
                    if (mode_reg)
                    begin
                        if (phase_inc == time_phase)
                        begin
                            mode_next  = 1'b0;
                            phase_next = '0;
                        end
                    end
                    else if (phase_inc == temp_phase)
                    begin
                        light_next = item.light_sample;
                        neg_next   = item.temp_tenths[TEMP_W-1];
                        mag_next   = sample_mag;
                        mode_next  = 1'b1;
                        phase_next = '0;
                    end

                    if (sec_reg >= SEC_LAST)
                    begin
                        sec_next    = '0;
                        report_next = 1'b1;
                        if (min_reg >= MIN_LAST)
                        begin
                            min_next  = '0;
                            hour_next = (hour_reg >= HOUR_LAST) ? '0 : hour_reg + 1'b1;
                        end
                        else
                        begin
                            min_next = min_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sec_next = sec_reg + 1'b1;
                    end
                end
            end
        end
        else if (snap_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            sec_reg    <= '0;
            min_reg    <= '0;
            hour_reg   <= '0;
            mode_reg   <= 1'b1;
            phase_reg  <= '0;
            mag_reg    <= '0;
            neg_reg    <= 1'b0;
            light_reg  <= '0;
            report_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            tick_reg   <= tick_next;
            sec_reg    <= sec_next;
            min_reg    <= min_next;
            hour_reg   <= hour_next;
            mode_reg   <= mode_next;
            phase_reg  <= phase_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            light_reg  <= light_next;
            report_reg <= report_next;
            valid_reg  <= valid_next;
        end
    end

    assign snap_valid        = valid_reg;
    assign snap.hours        = hour_reg;
    assign snap.minutes      = min_reg;
    assign snap.seconds      = sec_reg;
    assign snap.showing_time = mode_reg;
    assign snap.report       = report_reg;
    assign snap.light        = light_reg;
    assign snap.negative     = neg_reg;
    assign snap.magnitude    = mag_reg;

endmodule

// ===== rtl/cwad_fmt.sv =====
`timescale 1ns / 1ps
// Segment encoding and report gating into the result register.
// Depends on cwad_pkg.
module cwad_fmt
    import cwad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             snap_valid,
    output logic             snap_ready,
    input  cwad_snap_t       snap,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [71:0]      out_data,
    output logic [1:0]       out_user
);

    logic               valid_reg;
    logic [71:0]        data_reg,  data_next;
    logic [1:0]         user_reg,  user_next;

    cwad_digits_t       hour_d, min_d, frac_d;
    logic [4:0]         hund;
    logic [6:0]         hund100;
    logic [MAG_W-1:0]   rem;
    logic [SEG_W-1:0]   s1, s2, s3, s4;
    logic [LIGHT_W-1:0] rep_light;
    logic               rep_neg;
    logic [MAG_W-1:0]   rep_mag;

    assign snap_ready = !valid_reg || out_ready;

    assign hour_d  = split_tens({2'b00, snap.hours});
    assign min_d   = split_tens({1'b0, snap.minutes});
    assign hund    = hundreds_of(snap.magnitude);
    // hund * 100 fits 11 bits (at most 2000)
    assign rem     = snap.magnitude - ({hund, 6'b0} + {1'b0, hund, 5'b0} + {4'b0, hund, 2'b0});
    assign hund100 = rem[6:0];
    assign frac_d  = split_tens(hund100);

    always_comb
    begin
        if (snap.showing_time)
        begin
            s1 = seg_of({1'b0, hour_d.tens});
            s2 = seg_of({1'b0, hour_d.units}) | SEG_POINT;
            s3 = seg_of({1'b0, min_d.tens});
            s4 = seg_of({1'b0, min_d.units});
        end
        else
        begin
            s1 = SEG_BLANK;
            s2 = seg_of(hund);
            s3 = seg_of({1'b0, frac_d.tens}) | SEG_POINT;
            s4 = seg_of({1'b0, frac_d.units});
        end
        rep_light = snap.report ? snap.light     : '0;
        rep_neg   = snap.report ? snap.negative  : 1'b0;
        rep_mag   = snap.report ? snap.magnitude : '0;
        data_next = {3'b000, rep_mag, rep_neg, rep_light, s4, s3, s2, s1,
                     snap.seconds, snap.minutes, snap.hours};
        user_next = {snap.report, snap.showing_time};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (snap_ready)
            valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule
